/* rtl/core/udprl_pkg.sv */
// ----------------------------------------------------------------------------
// udprl_pkg
// shared types and constants of the udp sliding window rate limiter
// ----------------------------------------------------------------------------
package udprl_pkg;

   // default geometry of the timestamp log
   localparam int LOG_DEPTH_DEF  = 64;
   localparam int TIME_WIDTH_DEF = 32;

   // fixed field widths
   localparam int ETHER_W    = 16;
   localparam int PROTO_W    = 8;
   localparam int ADDR_W     = 32;
   localparam int ARRIVAL_W  = 32;
   localparam int VERDICT_W  = 2;
   localparam int WCOUNT_W   = 7;
   localparam int LIMIT_W    = 6;
   localparam int WINDOW_W   = 31;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 32;

   // frame classification
   localparam logic [ETHER_W-1:0] ETHER_IPV4 = 16'h0800;
   localparam logic [PROTO_W-1:0] PROTO_UDP  = 8'd17;

   // verdict codes
   localparam logic [VERDICT_W-1:0] VERDICT_FORWARD = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_NOT_IP  = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_NOT_UDP = 2'd2;
   localparam logic [VERDICT_W-1:0] VERDICT_DROP    = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PACKET_LIMIT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_TICKS = 8'd1;

   // register reset values
   localparam logic [LIMIT_W-1:0]  PACKET_LIMIT_RST = 6'd50;
   localparam logic [WINDOW_W-1:0] WINDOW_TICKS_RST = 31'd5000;

   typedef struct packed {
      logic [LIMIT_W-1:0]  packet_limit;
      logic [WINDOW_W-1:0] window_ticks;
   } udprl_cfg_type;

endpackage

/* rtl/core/udprl_ram.sv */
// ----------------------------------------------------------------------------
// udprl_ram
// generic simple dual port ram, one write port, registered read port
// ----------------------------------------------------------------------------
module udprl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/udprl_csr.sv */
// ----------------------------------------------------------------------------
// udprl_csr
// configuration registers, written through a valid/ready port
// ----------------------------------------------------------------------------
module udprl_csr
   import udprl_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output udprl_cfg_type         cfg
);

   udprl_cfg_type cfg_ff;
   udprl_cfg_type cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PACKET_LIMIT: cfg_in.packet_limit = csr_wdata[LIMIT_W-1:0];
            CSR_WINDOW_TICKS: cfg_in.window_ticks = csr_wdata[WINDOW_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.packet_limit <= PACKET_LIMIT_RST;
         cfg_ff.window_ticks <= WINDOW_TICKS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/udp_sliding_window_rate_limiter.sv */
// latency: a rejected frame, or a udp packet into an empty log, shows its result
//   in the cycle after the input transfer; any other udp packet first runs the
//   read-compare loop over the log ram's single read port, popping expired entries
// throughput: one rejected frame or udp packet into an empty log per cycle unless
//   the result stalls; the read-compare loop holds off new descriptors until done
// reset: pointer, count, registers and state clear at once; the log ram is not
//   cleared (entries are only read after being written), so no sweep is needed
// ----------------------------------------------------------------------------
// udp_sliding_window_rate_limiter
// classifies packet descriptors and rate limits udp traffic with a circular
// log of arrival timestamps held in a synchronous ram
// ----------------------------------------------------------------------------
module udp_sliding_window_rate_limiter
   import udprl_pkg::*;
#(
   parameter int LOG_DEPTH  = LOG_DEPTH_DEF,
   parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // packet descriptor channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [ETHER_W-1:0]    req_ether_kind,
   input  logic [PROTO_W-1:0]    req_ip_protocol,
   input  logic [ADDR_W-1:0]     req_source_addr,
   input  logic [ADDR_W-1:0]     req_dest_addr,
   input  logic [ARRIVAL_W-1:0]  req_arrival_time,
   // result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [VERDICT_W-1:0]  rsp_verdict,
   output logic [ADDR_W-1:0]     rsp_out_source_addr,
   output logic [ADDR_W-1:0]     rsp_out_dest_addr,
   output logic [WCOUNT_W-1:0]   rsp_window_count,
   // configuration channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int PTR_W = $clog2(LOG_DEPTH);
   localparam int CNT_W = $clog2(LOG_DEPTH + 1);
   localparam int SUM_W = PTR_W + 1;
   // age compare width, wide enough for both the age and the window register
   localparam int CMP_W = (TIME_WIDTH > WINDOW_W) ? TIME_WIDTH : WINDOW_W;
   // count compare width against the packet limit
   localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

   typedef enum logic {
      ST_IDLE,
      ST_CHECK
   } state_type;

   udprl_cfg_type cfg;

   // sequencer state
   state_type             state_ff, state_in;
   logic [PTR_W-1:0]      oldest_ff, oldest_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [TIME_WIDTH-1:0] now_ff, now_in;
   logic [ADDR_W-1:0]     src_ff, src_in;
   logic [ADDR_W-1:0]     dst_ff, dst_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0]  rsp_verdict_ff, rsp_verdict_in;
   logic [ADDR_W-1:0]     rsp_src_ff, rsp_src_in;
   logic [ADDR_W-1:0]     rsp_dst_ff, rsp_dst_in;
   logic [WCOUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   // log ram ports
   logic                  wr_en;
   logic [PTR_W-1:0]      wr_addr;
   logic [PTR_W-1:0]      rd_addr;
   logic [TIME_WIDTH-1:0] rd_data;

   // datapath helpers
   logic                          out_free;
   logic                          accept;
   logic                          log_full;
   logic [PTR_W-1:0]              ptr_next;
   logic [SUM_W-1:0]              tail_sum;
   logic [PTR_W-1:0]              tail_idx;
   logic [TIME_WIDTH+ARRIVAL_W-1:0] arrival_ext;
   logic [TIME_WIDTH-1:0]         req_now;
   logic [TIME_WIDTH-1:0]         age;
   logic                          expired;

   // drop when more than the limit remain in the window
   function automatic logic [VERDICT_W-1:0] rate_verdict(
      input logic [CNT_W-1:0]   cnt,
      input logic [LIMIT_W-1:0] limit
   );
      logic drop;
      drop = LIM_W'(cnt) > LIM_W'(limit);
      return drop ? VERDICT_DROP : VERDICT_FORWARD;
   endfunction

   // reported count is the log occupancy masked to the field width
   function automatic logic [WCOUNT_W-1:0] report_count(input logic [CNT_W-1:0] cnt);
      logic [CNT_W+WCOUNT_W-1:0] wide;
      wide = {{WCOUNT_W{1'b0}}, cnt};
      return wide[WCOUNT_W-1:0];
   endfunction

   udprl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // timestamp log
   udprl_ram #(
      .WIDTH (TIME_WIDTH),
      .DEPTH (LOG_DEPTH)
   ) u_log (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_now),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // a new item enters only in idle and only when the output register is free
   // or being emptied, so a finished udp result never finds it occupied
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   // timestamp reduced modulo 2^TIME_WIDTH
   assign arrival_ext = {{TIME_WIDTH{1'b0}}, req_arrival_time};
   assign req_now     = arrival_ext[TIME_WIDTH-1:0];

   assign log_full = (count_ff == CNT_W'(LOG_DEPTH));
   assign ptr_next = (oldest_ff == PTR_W'(LOG_DEPTH - 1)) ? '0 : oldest_ff + 1'b1;

   // append slot, oldest + count wrapped once; count < depth when not full
   assign tail_sum = {1'b0, oldest_ff} + {1'b0, count_ff[PTR_W-1:0]};
   always_comb begin
      if (tail_sum >= SUM_W'(LOG_DEPTH)) begin
         tail_idx = PTR_W'(tail_sum - SUM_W'(LOG_DEPTH));
      end else begin
         tail_idx = tail_sum[PTR_W-1:0];
      end
   end

   // age of the oldest entry, read out of the ram the cycle before
   assign age     = now_ff - rd_data;
   assign expired = CMP_W'(age) > CMP_W'(cfg.window_ticks);

   always_comb begin
      state_in       = state_ff;
      oldest_in      = oldest_ff;
      count_in       = count_ff;
      now_in         = now_ff;
      src_in         = src_ff;
      dst_in         = dst_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_src_in     = rsp_src_ff;
      rsp_dst_in     = rsp_dst_ff;
      rsp_count_in   = rsp_count_ff;
      wr_en          = 1'b0;
      wr_addr        = tail_idx;
      rd_addr        = oldest_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               src_in = req_source_addr;
               dst_in = req_dest_addr;
               now_in = req_now;
               if (req_ether_kind != ETHER_IPV4) begin
                  // not ipv4, state untouched
                  rsp_valid_in   = 1'b1;
                  rsp_verdict_in = VERDICT_NOT_IP;
                  rsp_src_in     = req_source_addr;
                  rsp_dst_in     = req_dest_addr;
                  rsp_count_in   = report_count(count_ff);
               end else if (req_ip_protocol != PROTO_UDP) begin
                  // not udp, state untouched
                  rsp_valid_in   = 1'b1;
                  rsp_verdict_in = VERDICT_NOT_UDP;
                  rsp_src_in     = req_source_addr;
                  rsp_dst_in     = req_dest_addr;
                  rsp_count_in   = report_count(count_ff);
               end else begin
                  wr_en = 1'b1;
                  if (log_full) begin
                     // overwrite the oldest entry, the next one becomes oldest
                     wr_addr   = oldest_ff;
                     oldest_in = ptr_next;
                     rd_addr   = ptr_next;
                  end else begin
                     wr_addr  = tail_idx;
                     count_in = count_ff + 1'b1;
                     rd_addr  = oldest_ff;
                  end
                  if (count_ff == '0) begin
                     // lone entry has age zero and always stays
                     rsp_valid_in   = 1'b1;
                     rsp_verdict_in = rate_verdict(CNT_W'(1), cfg.packet_limit);
                     rsp_src_in     = req_source_addr;
                     rsp_dst_in     = req_dest_addr;
                     rsp_count_in   = report_count(CNT_W'(1));
                  end else begin
                     // read slot differs from the write slot, no forwarding needed
                     state_in = ST_CHECK;
                  end
               end
            end
         end
         ST_CHECK: begin
            if (expired) begin
               // pop the oldest and fetch the next one; the new entry never expires
               oldest_in = ptr_next;
               count_in  = count_ff - 1'b1;
               rd_addr   = ptr_next;
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_verdict_in = rate_verdict(count_ff, cfg.packet_limit);
               rsp_src_in     = src_ff;
               rsp_dst_in     = dst_ff;
               rsp_count_in   = report_count(count_ff);
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         oldest_ff    <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      now_ff         <= now_in;
      src_ff         <= src_in;
      dst_ff         <= dst_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_src_ff     <= rsp_src_in;
      rsp_dst_ff     <= rsp_dst_in;
      rsp_count_ff   <= rsp_count_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_verdict         = rsp_verdict_ff;
   assign rsp_out_source_addr = rsp_src_ff;
   assign rsp_out_dest_addr   = rsp_dst_ff;
   assign rsp_window_count    = rsp_count_ff;

endmodule

/* bench/tb_udp_sliding_window_rate_limiter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_udp_sliding_window_rate_limiter
// drives packet descriptors through the rate limiter and checks every verdict
// against a timestamp log kept inside the bench
// ----------------------------------------------------------------------------
module tb_udp_sliding_window_rate_limiter;
   import udprl_pkg::*;

   localparam int DEPTH        = LOG_DEPTH_DEF;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int TAIL_CYCLES  = 100;
   localparam int RESET_CYCLES = 12;
   localparam int OWED_DEPTH   = 16;

   typedef struct packed {
      logic [ETHER_W-1:0]   ether_kind;
      logic [PROTO_W-1:0]   ip_protocol;
      logic [ADDR_W-1:0]    source_addr;
      logic [ADDR_W-1:0]    dest_addr;
      logic [ARRIVAL_W-1:0] arrival_time;
   } descriptor_type;

   typedef struct packed {
      logic [VERDICT_W-1:0] verdict;
      logic [ADDR_W-1:0]    source_addr;
      logic [ADDR_W-1:0]    dest_addr;
      logic [WCOUNT_W-1:0]  window_count;
   } verdict_rec_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [ETHER_W-1:0]    req_ether_kind;
   logic [PROTO_W-1:0]    req_ip_protocol;
   logic [ADDR_W-1:0]     req_source_addr;
   logic [ADDR_W-1:0]     req_dest_addr;
   logic [ARRIVAL_W-1:0]  req_arrival_time;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [VERDICT_W-1:0]  rsp_verdict;
   logic [ADDR_W-1:0]     rsp_out_source_addr;
   logic [ADDR_W-1:0]     rsp_out_dest_addr;
   logic [WCOUNT_W-1:0]   rsp_window_count;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // bench copy of the limiter state: circular log of udp arrival stamps
   logic [ARRIVAL_W-1:0]  stamp_log [DEPTH];
   logic [5:0]            stamp_head;
   logic [WCOUNT_W-1:0]   stamp_count;
   logic [LIMIT_W-1:0]    limit_reg;
   logic [WINDOW_W-1:0]   window_reg;

   // verdicts still owed by the block, oldest first, kept in a small ring
   verdict_rec_type       expected_verdicts [OWED_DEPTH];
   int                    owed_wr_idx   = 0;
   int                    owed_rd_idx   = 0;

   int                    error_count   = 0;
   int                    cycle_count   = 0;
   int unsigned           send_idle_pct = 0;
   int unsigned           stall_pct     = 0;
   logic [ARRIVAL_W-1:0]  last_stamp;

   // number of verdicts still owed
   function automatic int owed_count();
      return owed_wr_idx - owed_rd_idx;
   endfunction

   udp_sliding_window_rate_limiter dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_ether_kind      (req_ether_kind),
      .req_ip_protocol     (req_ip_protocol),
      .req_source_addr     (req_source_addr),
      .req_dest_addr       (req_dest_addr),
      .req_arrival_time    (req_arrival_time),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_verdict         (rsp_verdict),
      .rsp_out_source_addr (rsp_out_source_addr),
      .rsp_out_dest_addr   (rsp_out_dest_addr),
      .rsp_window_count    (rsp_window_count),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always #1 clock = ~clock;

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d verdicts outstanding",
                  $time, cycle_count, owed_count());
         $display("** udp_sliding_window_rate_limiter: FAILED **");
         $finish;
      end
   end

   // classify one descriptor and update the bench log the way the block should
   function automatic verdict_rec_type judge_packet(input descriptor_type d);
      verdict_rec_type r;
      logic [5:0]      slot;
      r.source_addr = d.source_addr;
      r.dest_addr   = d.dest_addr;
      if (d.ether_kind != ETHER_IPV4) begin
         r.verdict = VERDICT_NOT_IP;
      end else if (d.ip_protocol != PROTO_UDP) begin
         r.verdict = VERDICT_NOT_UDP;
      end else begin
         // full log: newest stamp replaces the oldest one
         if (stamp_count == DEPTH) begin
            stamp_log[stamp_head] = d.arrival_time;
            stamp_head++;
         end else begin
            slot = stamp_head + stamp_count[5:0];
            stamp_log[slot] = d.arrival_time;
            stamp_count++;
         end
         // age is taken mod 2^32, only the oldest end is ever retired
         while (stamp_count != 0 &&
                ARRIVAL_W'(d.arrival_time - stamp_log[stamp_head]) > {1'b0, window_reg}) begin
            stamp_head++;
            stamp_count--;
         end
         r.verdict = (stamp_count > limit_reg) ? VERDICT_DROP : VERDICT_FORWARD;
      end
      r.window_count = stamp_count;
      return r;
   endfunction

   function automatic descriptor_type make_descriptor(input logic [ETHER_W-1:0] ether,
                                                      input logic [PROTO_W-1:0] proto,
                                                      input logic [ADDR_W-1:0] src,
                                                      input logic [ADDR_W-1:0] dst,
                                                      input logic [ARRIVAL_W-1:0] stamp);
      descriptor_type d;
      d.ether_kind   = ether;
      d.ip_protocol  = proto;
      d.source_addr  = src;
      d.dest_addr    = dst;
      d.arrival_time = stamp;
      return d;
   endfunction

   // mostly udp at a steady pace, some rejects, some stamp jumps and steps back
   function automatic descriptor_type random_descriptor(input int unsigned span);
      descriptor_type d;
      int unsigned    pick;
      d = make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom, '0);
      pick = $urandom_range(99);
      if (pick < 6)
         d.ether_kind = ETHER_W'($urandom);
      else if (pick < 12)
         d.ip_protocol = PROTO_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 3)
         last_stamp = $urandom;
      else if (pick < 6)
         last_stamp = last_stamp - $urandom_range(span);
      else
         last_stamp = last_stamp + $urandom_range(span);
      d.arrival_time = last_stamp;
      return d;
   endfunction

   // one descriptor transfer, with random idle cycles ahead of it
   task automatic send_descriptor(input descriptor_type d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_ether_kind   <= d.ether_kind;
      req_ip_protocol  <= d.ip_protocol;
      req_source_addr  <= d.source_addr;
      req_dest_addr    <= d.dest_addr;
      req_arrival_time <= d.arrival_time;
      do @(posedge clock); while (req_stall);
      expected_verdicts[owed_wr_idx % OWED_DEPTH] = judge_packet(d);
      owed_wr_idx++;
   endtask

   // hold off the sender until every owed verdict is back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (owed_count() != 0)
         @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_PACKET_LIMIT)
         limit_reg = data[LIMIT_W-1:0];
      else if (idx == CSR_WINDOW_TICKS)
         window_reg = data[WINDOW_W-1:0];
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // unused upper bits carry random junk, the block must ignore them
   task automatic set_limit(input int unsigned lim);
      write_register(CSR_PACKET_LIMIT, ($urandom & ~32'h3F) | (lim & 32'h3F));
   endtask

   task automatic set_window(input int unsigned win);
      write_register(CSR_WINDOW_TICKS, ($urandom & 32'h8000_0000) | (win & 32'h7FFF_FFFF));
   endtask

   task automatic check_field(input string what, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, want, got);
         error_count++;
      end
   endtask

   // result side: random stall, compare each transfer with the oldest verdict owed
   always @(posedge clock) begin : result_check
      verdict_rec_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_count() == 0) begin
               $display("%0t: unexpected result, expected none actual verdict %0h",
                        $time, rsp_verdict);
               error_count++;
            end else begin
               want = expected_verdicts[owed_rd_idx % OWED_DEPTH];
               owed_rd_idx++;
               check_field("verdict", 32'(want.verdict), 32'(rsp_verdict));
               check_field("source_addr", want.source_addr, rsp_out_source_addr);
               check_field("dest_addr", want.dest_addr, rsp_out_dest_addr);
               check_field("window_count", 32'(want.window_count), 32'(rsp_window_count));
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // reset register values, reject paths, field extremes, stamp wrap and step back
   task automatic test_reset_values();
      send_descriptor(make_descriptor(16'h0000, PROTO_UDP, 32'h0, 32'hFFFF_FFFF, 32'h0));
      send_descriptor(make_descriptor(16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
      send_descriptor(make_descriptor(16'h0801, PROTO_UDP, $urandom, $urandom, 32'h0));
      send_descriptor(make_descriptor(ETHER_IPV4, 8'h00, $urandom, $urandom, 32'h0));
      send_descriptor(make_descriptor(ETHER_IPV4, 8'hFF, $urandom, $urandom, 32'h0));
      send_descriptor(make_descriptor(ETHER_IPV4, 8'd16, $urandom, $urandom, 32'h0));
      // first udp packet into an empty log, then one more at the same stamp
      send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, 32'h0, 32'hFFFF_FFFF, 32'd0));
      send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, 32'hFFFF_FFFF, 32'h0, 32'd0));
      // reject with a populated log keeps the count
      send_descriptor(make_descriptor(16'h86DD, PROTO_UDP, $urandom, $urandom, 32'd10));
      // age equal to the window stays, one tick more expires
      send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom, 32'd5000));
      send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom, 32'd5001));
      // far jump, then wrap past zero
      send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom,
                                      32'hFFFF_FFFF));
      send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom, 32'h10));
      // stamp goes backwards, newer entry must not be retired out of order
      send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom, 32'h1));
      send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom, 32'h1000));
   endtask

   // zero, one and largest window
   task automatic test_window_edges();
      logic [ARRIVAL_W-1:0] t0;
      t0 = 32'h1234_0000;
      wait_for_results();
      set_window(0);
      set_limit(2);
      repeat (3)
         send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom, t0));
      send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom, t0 + 1));
      wait_for_results();
      set_window(1);
      send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom, t0 + 2));
      send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom, t0 + 3));
      wait_for_results();
      set_window(32'h7FFF_FFFF);
      set_limit(63);
      send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom,
                                      t0 + 32'h8000_0002));
      last_stamp = t0 + 32'h8000_0002;
   endtask

   // limit zero drops everything, limit 63 with a full log drops past 63
   task automatic test_limit_edges();
      logic [ARRIVAL_W-1:0] base;
      wait_for_results();
      set_limit(0);
      set_window(5000);
      send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom, last_stamp));
      send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom, last_stamp));
      wait_for_results();
      set_limit(63);
      set_window(32'h7FFF_FFFF);
      base = last_stamp + 32'h100;
      // 70 packets in one tick wrap the log around
      repeat (70)
         send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom, base));
      send_descriptor(make_descriptor(ETHER_IPV4, 8'd6, $urandom, $urandom, base));
      // whole log expires behind one packet
      send_descriptor(make_descriptor(ETHER_IPV4, PROTO_UDP, $urandom, $urandom,
                                      base + 32'h8000_0000));
      last_stamp = base + 32'h8000_0000;
   endtask

   // random traffic over several settings and handshake pressure mixes
   task automatic test_random_traffic();
      int unsigned     lim;
      int unsigned     win;
      longint unsigned span;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin lim = 63; win = 32'h7FFF_FFFF; end
            1: begin lim = 0;  win = 1; end
            2: begin lim = 12; win = 300; end
            3: begin lim = 50; win = 5000; end
            4: begin lim = $urandom_range(63, 1); win = $urandom_range(2000, 2); end
            5: begin lim = 63; win = 64; end
            6: begin lim = 1;  win = 0; end
            default: begin lim = $urandom_range(63); win = $urandom_range(32'h7FFF_FFFF); end
         endcase
         wait_for_results();
         set_limit(lim);
         set_window(win);
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 59; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 59; end
            default: begin send_idle_pct = 36; stall_pct = 36; end
         endcase
         // stamp step chosen so the window holds roughly limit + 1 packets
         span = (2 * longint'(win)) / (lim + 1) + 1;
         if (span > 64'hFFFF_FFFF)
            span = 64'hFFFF_FFFF;
         repeat (63)
            send_descriptor(random_descriptor(int'(span)));
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_ether_kind   = '0;
      req_ip_protocol  = '0;
      req_source_addr  = '0;
      req_dest_addr    = '0;
      req_arrival_time = '0;
      csr_valid        = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      stamp_head       = '0;
      stamp_count      = '0;
      limit_reg        = PACKET_LIMIT_RST;
      window_reg       = WINDOW_TICKS_RST;
      last_stamp       = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_window_edges();
      test_limit_edges();
      test_random_traffic();

      // drain, then give late or extra transfers a chance to show up
      wait_for_results();
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && owed_count() == 0) begin
         $display("** udp_sliding_window_rate_limiter: PASSED **");
      end else begin
         $display("%0t: %0d mismatches, %0d verdicts never arrived",
                  $time, error_count, owed_count());
         $display("** udp_sliding_window_rate_limiter: FAILED **");
      end
      $finish;
   end

endmodule
